>>> design/multidim_subscript_to_linear_index_macros.svh
// Assertion macros shared by the linear index generator.
`ifndef MULTIDIM_SUBSCRIPT_TO_LINEAR_INDEX_MACROS_SVH
`define MULTIDIM_SUBSCRIPT_TO_LINEAR_INDEX_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MSLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MSLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/msli_pkg.sv
// Package: types, codes and defaults of the linear index generator.
package msli_pkg;

  localparam int unsigned MAX_DIMS_DEF = 4;
  localparam int unsigned MAX_LIST_DEF = 256;
  localparam int unsigned HW_DIMS      = 4;
  localparam int unsigned SUB_W        = 16;
  localparam int unsigned LIN_W        = 64;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_FETCH  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMS = 3'd0,
    CFG_EXT0 = 3'd1,
    CFG_EXT1 = 3'd2,
    CFG_EXT2 = 3'd3,
    CFG_EXT3 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [1:0]       dim_select;
    logic [SUB_W-1:0] subscript;
    logic             subscript_missing;
  } in_item_t;

  typedef struct packed {
    logic [LIN_W-1:0] linear_index;
    logic             index_missing;
    logic             last;
    logic             empty_res;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic append;
    logic clear;
    logic fetch_start;
    logic rd;
    logic mul_lo;
    logic mul_hi;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic empty;
    logic dim_zero;
  } dp_status_t;

endpackage

>>> design/msli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msli_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/msli_ctrl.sv
// Controller: sequences append, clear and fetch transfers.
module msli_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  msli_pkg::cmd_e      in_cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  msli_pkg::dp_status_t status_i,
  output msli_pkg::ctrl_cmd_t cmd_o
);
  import msli_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_MUL_LO = 5'b00100,
    ST_MUL_HI = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.append      = (in_cmd_i == CMD_APPEND);
          cmd_o.clear       = (in_cmd_i == CMD_CLEAR);
          cmd_o.fetch_start = (in_cmd_i == CMD_FETCH);
          if (in_cmd_i == CMD_FETCH) begin
            state_d = status_i.empty ? ST_DONE : ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = status_i.dim_zero ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/msli_dpath.sv
// Datapath: config registers, subscript lists, odometer and index accumulator.
module msli_dpath #(
  parameter int unsigned MAX_DIMS = msli_pkg::MAX_DIMS_DEF,
  parameter int unsigned MAX_LIST = msli_pkg::MAX_LIST_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  msli_pkg::ctrl_cmd_t               cmd_i,
  output msli_pkg::dp_status_t              status_o,
  input  msli_pkg::in_item_t                in_data_i,
  input  logic                              cfg_valid_i,
  input  logic [msli_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [msli_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output msli_pkg::out_item_t               out_data_o
);
  import msli_pkg::*;

  localparam int unsigned DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned POS_W = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_LIST + 1);
  localparam int unsigned DEPTH = MAX_DIMS * MAX_LIST;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ENT_W = SUB_W + 1;

  // configuration
  logic [2:0]       dims_q;
  logic [SUB_W-1:0] ext_q [HW_DIMS];
  logic [2:0]       nd;

  // list and odometer state
  logic [LEN_W-1:0] len_q [MAX_DIMS];
  logic [LEN_W-1:0] len_d [MAX_DIMS];
  logic [POS_W-1:0] pos_q [MAX_DIMS];
  logic [POS_W-1:0] pos_d [MAX_DIMS];
  logic [POS_W-1:0] pc    [MAX_DIMS];
  logic [POS_W-1:0] pos_adv [MAX_DIMS];
  logic             carry;
  logic             empty;

  // fetch accumulator
  logic [DIM_W-1:0] cur_dim_q;
  logic [LIN_W-1:0] acc_q;
  logic [47:0]      prod_lo_q;
  logic [SUB_W-1:0] term_q;
  logic             miss_q;
  logic             last_q;
  logic             empty_q;
  out_item_t        out_q;

  logic [DIM_W-1:0] dsel_idx;
  logic             app_ok;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [ENT_W-1:0] rdata;
  logic [SUB_W-1:0] ext_cur;
  logic [SUB_W-1:0] sub_rd;
  logic             miss_dim;
  logic [47:0]      prod_lo;
  logic [31:0]      prod_hi;

  assign nd = (dims_q > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : dims_q;

  // clamp stale positions to the list start
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      pc[d] = (LEN_W'(pos_q[d]) >= len_q[d]) ? '0 : pos_q[d];
    end
  end

  always_comb begin
    empty = (nd == 3'd0);
    for (int d = 0; d < MAX_DIMS; d++) begin
      if ((3'(d) < nd) && (len_q[d] == '0)) begin
        empty = 1'b1;
      end
    end
  end

  // odometer step, first dimension fastest
  always_comb begin
    carry = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      pos_adv[d] = pos_q[d];
      if ((3'(d) < nd) && carry) begin
        if ((LEN_W'(pc[d]) + LEN_W'(1)) < len_q[d]) begin
          pos_adv[d] = pc[d] + POS_W'(1);
          carry      = 1'b0;
        end else begin
          pos_adv[d] = '0;
        end
      end
    end
  end

  assign dsel_idx = in_data_i.dim_select[DIM_W-1:0];
  assign app_ok   = (3'(in_data_i.dim_select) < 3'(MAX_DIMS)) &&
                    (len_q[dsel_idx] < LEN_W'(MAX_LIST));
  assign waddr    = AW'(32'(dsel_idx) * 32'(MAX_LIST) +
                        32'(len_q[dsel_idx][POS_W-1:0]));
  assign raddr    = AW'(32'(cur_dim_q) * 32'(MAX_LIST) + 32'(pc[cur_dim_q]));

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      len_d[d] = len_q[d];
      pos_d[d] = pos_q[d];
      if (cmd_i.clear) begin
        len_d[d] = '0;
      end else if (cmd_i.append && app_ok && (DIM_W'(d) == dsel_idx)) begin
        len_d[d] = len_q[d] + LEN_W'(1);
      end
      if (cmd_i.clear || cmd_i.append) begin
        pos_d[d] = '0;
      end else if (cmd_i.load_out && !empty_q) begin
        pos_d[d] = pos_adv[d];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= '0;
      for (int i = 0; i < HW_DIMS; i++) begin
        ext_q[i] <= SUB_W'(1);
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
        len_q[d] <= '0;
        pos_q[d] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DIMS: dims_q   <= cfg_data_i[2:0];
          CFG_EXT0: ext_q[0] <= cfg_data_i;
          CFG_EXT1: ext_q[1] <= cfg_data_i;
          CFG_EXT2: ext_q[2] <= cfg_data_i;
          CFG_EXT3: ext_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
        len_q[d] <= len_d[d];
        pos_q[d] <= pos_d[d];
      end
    end
  end

  msli_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.append && app_ok),
    .waddr_i(waddr),
    .wdata_i({in_data_i.subscript_missing, in_data_i.subscript}),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign ext_cur  = ext_q[2'(cur_dim_q)];
  assign sub_rd   = rdata[SUB_W-1:0];
  assign miss_dim = rdata[SUB_W] || (sub_rd == '0) || (sub_rd > ext_cur);
  assign prod_lo  = acc_q[31:0] * ext_cur;
  assign prod_hi  = acc_q[47:32] * ext_cur;

  // Horner accumulation from the highest dimension down
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_start) begin
      cur_dim_q <= DIM_W'(nd - 3'd1);
      acc_q     <= '0;
      miss_q    <= 1'b0;
      last_q    <= 1'b1;
      empty_q   <= empty;
    end
    if (cmd_i.mul_lo) begin
      prod_lo_q <= prod_lo;
      term_q    <= miss_dim ? '0 : (sub_rd - SUB_W'(1));
      miss_q    <= miss_q || miss_dim;
      last_q    <= last_q && ((LEN_W'(pc[cur_dim_q]) + LEN_W'(1)) == len_q[cur_dim_q]);
    end
    if (cmd_i.mul_hi) begin
      acc_q <= LIN_W'(prod_lo_q) + {prod_hi, 32'd0} + LIN_W'(term_q);
      if (cur_dim_q != '0) begin
        cur_dim_q <= cur_dim_q - DIM_W'(1);
      end
    end
    if (cmd_i.load_out) begin
      if (empty_q) begin
        out_q <= '{linear_index: '0, index_missing: 1'b0, last: 1'b0, empty_res: 1'b1};
      end else begin
        out_q <= '{linear_index: miss_q ? '0 : acc_q, index_missing: miss_q,
                   last: last_q, empty_res: 1'b0};
      end
    end
  end

  assign status_o.empty    = empty;
  assign status_o.dim_zero = (cur_dim_q == '0);
  assign out_data_o        = out_q;

endmodule

>>> design/multidim_subscript_to_linear_index.sv
// Top level: column-major linear index generator over loaded subscript lists.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  in_data_i   (cmd, dim, subscript, NA)
//   out      output     out_valid_o/out_ready_i out_data_o (index, missing, last, empty)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Append, clear and unused commands complete in IDLE. A fetch runs READ, MUL_LO and
// MUL_HI for each dimension in use, then DONE (straight to DONE when the product is
// empty): per dimension a store read and a 48x16 multiply in two <=32-bit halves.
// Reset (rst_ni, async, active low) empties every list and rewinds the odometer;
// the subscript store is not cleared. in_ready_o drops while a fetch runs and
// while its result waits for a free output register; cfg_ready_o stays high.
module multidim_subscript_to_linear_index #(
  parameter int unsigned MAX_DIMS = msli_pkg::MAX_DIMS_DEF,
  parameter int unsigned MAX_LIST = msli_pkg::MAX_LIST_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  msli_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output msli_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [msli_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [msli_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import msli_pkg::*;

  `include "multidim_subscript_to_linear_index_macros.svh"

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // Configuration writes go straight into the config registers; never stall them.
  assign cfg_ready_o = 1'b1;

  // Controller: accept transfers, step through dimensions, hand off the result.
  msli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_cmd_i   (in_data_i.cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // Datapath: lists in a RAM, odometer, Horner accumulation, output register.
  msli_dpath #(
    .MAX_DIMS(MAX_DIMS),
    .MAX_LIST(MAX_LIST)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctrl_cmd),
    .status_o   (dp_status),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

  // A fetch transfer must make the block busy on the following cycle.
  `MSLI_ASSERT_NEXT(a_fetch_busy, in_valid_i && in_ready_o && (in_data_i.cmd == CMD_FETCH), !in_ready_o, "fetch did not hold off input")
  // Append, clear and unused commands leave the block ready on the following cycle.
  `MSLI_ASSERT_NEXT(a_short_cmd, in_valid_i && in_ready_o && (in_data_i.cmd != CMD_FETCH), in_ready_o, "short command stalled input")
  // Never overwrite a result that still waits for its transfer.
  `MSLI_ASSERT_NOW(a_no_overwrite, ctrl_cmd.load_out, !out_valid_o || out_ready_i, "pending result overwritten")

endmodule
